// ----- rtl/ceb_pkg.sv -----
// ---------------------------------------------------------------------------
// ceb_pkg: shared types and constants for the chirp bandwidth estimator
// Store depth, derived widths, store entry layout and sequencer states.
// ---------------------------------------------------------------------------
`default_nettype none
package ceb_pkg;

	localparam int MAX_PACKETS = 64;
	localparam int AW          = $clog2(MAX_PACKETS);      // store address bits
	localparam int CW          = $clog2(MAX_PACKETS + 1);  // packet count bits
	localparam int SUMW        = 32 + CW;                  // gap sum bits
	localparam int ACCW        = 64 + CW;                  // weighted rate sum bits
	localparam int EFFW        = 34;                       // signed effective delay

	localparam logic [7:0] DIVISOR_RST  = 8'd12;
	localparam logic [6:0] BUSY_MIN_RST = 7'd5;

	typedef enum logic {
		REG_DECREASE_DIVISOR = 1'b0,
		REG_BUSY_MIN_LENGTH  = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic [31:0] gap;
		logic [31:0] rate;
		logic        skip;
		logic [31:0] delay;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef enum logic [3:0] {
		S_LOAD,
		S_NR_RD,
		S_NR_W0,
		S_NR_W1,
		S_EXC,
		S_EXC_W,
		S_MARK,
		S_MARK_W,
		S_FIN,
		S_FIN_W,
		S_SUM,
		S_SUM_W,
		S_SUM_A,
		S_DIV,
		S_DIV_W,
		S_DONE
	} state_t;

	// skipped packets count as -1 ns
	function automatic logic signed [EFFW-1:0] eff_delay(input logic skip,
			input logic [31:0] delay);
		return skip ? -34'sd1 : $signed({2'b00, delay});
	endfunction

endpackage
`default_nettype wire

// ----- rtl/chirp_excursion_bandwidth.sv -----
// ---------------------------------------------------------------------------
// chirp_excursion_bandwidth: excursion-based available bandwidth of a chirp
// Stores one chirp, finds queuing excursions and emits the weighted rate.
// ---------------------------------------------------------------------------
// Usage:
//   s_* carries one probe packet per transaction; s_tlast closes the chirp.
//   Packets load one per cycle while s_tready is high. Beyond 64 stored
//   packets further packets are dropped and overflow is flagged.
//   After the closing packet s_tready stays low while a sequencer walks the
//   store through one read port: a rise search, the excursion tests on each
//   visited entry, marking, which visits each entry of a long excursion, the
//   weighted sum over the packets, and the divider (start, quotient steps,
//   done). The store read port and the divider set the time per chirp.
//   m_* carries one result per chirp; it is held in an output register, so
//   the next chirp loads while the result waits. A stalled receiver only
//   delays the end of the following chirp's computation.
//   cfg_* writes a register, allowed only while idle.
//   Reset (arst_n low) empties the store, restores divisor 12 and minimum
//   excursion length 5, and drops any pending result.
// ---------------------------------------------------------------------------
`default_nettype none
module chirp_excursion_bandwidth (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cfg_we,
	input  wire logic         cfg_index,
	input  wire logic [7:0]   cfg_data,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [95:0]  s_tdata,   // queue_delay, probe_rate, arrival_gap
	input  wire logic         s_tuser,   // skip_mark
	input  wire logic         s_tlast,   // last_item
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic [31:0]       m_tdata,   // avail_bandwidth
	output logic [1:0]        m_tuser    // no_time_flag, overflow_flag
);
	import ceb_pkg::*;

	state_t state_q, state_d;

	logic [7:0]     divisor_q;
	logic [6:0]     busy_min_q;
	logic [CW-1:0]  count_q;
	logic           ovf_q;
	logic [CW-1:0]  last_q;
	logic [CW-1:0]  nr_i_q;
	logic [CW-1:0]  inc_q;
	logic [CW-1:0]  loc_q;
	logic [CW-1:0]  mk_q;
	logic [CW-1:0]  end_q;
	logic [CW-1:0]  k_q;
	logic signed [EFFW-1:0] cur_q;
	logic signed [EFFW-1:0] inc_delay_q;
	logic signed [EFFW-1:0] max_q;
	logic [MAX_PACKETS-1:0] mark_q;
	logic [31:0]    base_q;
	logic [63:0]    prod_s1;
	logic [SUMW-1:0] sum_q;
	logic [ACCW-1:0] acc_q;
	logic [31:0]    bw_q;
	logic           nt_q;
	logic           m_valid_q;
	logic [31:0]    m_bw_q;
	logic [1:0]     m_flags_q;

	logic           s_fire;
	logic           ram_we;
	logic [AW-1:0]  ram_raddr;
	logic [ENTRY_W-1:0] ram_rdata;
	entry_t         wr_entry;
	entry_t         rd;
	logic signed [EFFW-1:0] rd_eff;
	logic signed [EFFW-1:0] exc_d;
	logic signed [EFFW-1:0] exc_max;
	logic signed [43:0] exc_lhs;
	logic signed [43:0] exc_rhs;
	logic           exc_end;
	logic [8:0]     div_eff;
	logic [CW-1:0]  exc_len;
	logic [31:0]    sel_rate;
	logic           div_start;
	logic           div_done;
	logic [31:0]    div_quo;
	logic           out_free;

	assign s_tready = (state_q == S_LOAD);
	assign s_fire   = s_tvalid && s_tready;
	assign out_free = !m_valid_q || m_tready;

	assign wr_entry.delay = s_tdata[31:0];
	assign wr_entry.skip  = s_tuser;
	assign wr_entry.rate  = s_tdata[63:32];
	assign wr_entry.gap   = s_tdata[95:64];
	assign ram_we = s_fire && (count_q < CW'(MAX_PACKETS));

	ceb_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_PACKETS)) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (count_q[AW-1:0]),
		.wdata (wr_entry),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	ceb_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (acc_q),
		.divisor  (sum_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	// excursion datapath on the entry just read
	always_comb begin
		rd       = entry_t'(ram_rdata);
		rd_eff   = eff_delay(rd.skip, rd.delay);
		exc_d    = rd_eff - inc_delay_q;
		exc_max  = (exc_d > max_q) ? exc_d : max_q;
		div_eff  = (divisor_q == 8'd0) ? 9'd1 : {1'b0, divisor_q};
		exc_lhs  = 44'(exc_d) * $signed({35'd0, div_eff});
		exc_rhs  = 44'(exc_max) <<< 3;
		exc_end  = exc_lhs < exc_rhs;
		exc_len  = loc_q - inc_q;
		sel_rate = ((k_q < inc_q) && mark_q[k_q[AW-1:0]] && (rd.rate != 32'd0))
			? rd.rate : base_q;
	end

	// sequencer: next state, read address, divider start
	always_comb begin
		state_d   = state_q;
		ram_raddr = '0;
		div_start = 1'b0;
		unique case (state_q)
			S_LOAD: begin
				if (s_fire && s_tlast) state_d = S_NR_RD;
			end
			S_NR_RD: begin
				if (nr_i_q >= last_q) begin
					state_d = S_EXC;
				end else begin
					ram_raddr = nr_i_q[AW-1:0];
					state_d   = S_NR_W0;
				end
			end
			S_NR_W0: begin
				ram_raddr = AW'(nr_i_q + 1'b1);
				state_d   = S_NR_W1;
			end
			S_NR_W1: begin
				if (cur_q >= rd_eff && (nr_i_q + 1'b1) < last_q) begin
					ram_raddr = AW'(nr_i_q + CW'(2));
				end else begin
					state_d = S_EXC;
				end
			end
			S_EXC: begin
				if (loc_q > last_q) begin
					state_d = S_FIN;
				end else begin
					ram_raddr = loc_q[AW-1:0];
					state_d   = S_EXC_W;
				end
			end
			S_EXC_W: begin
				if (rd.skip || !exc_end) state_d = S_EXC;
				else if (32'(exc_len) >= 32'(busy_min_q)) state_d = S_MARK;
				else state_d = S_NR_RD;
			end
			S_MARK: begin
				ram_raddr = AW'(mk_q + 1'b1);
				state_d   = S_MARK_W;
			end
			S_MARK_W: begin
				if ((mk_q + 1'b1) < end_q) ram_raddr = AW'(mk_q + CW'(2));
				else state_d = S_NR_RD;
			end
			S_FIN: begin
				ram_raddr = AW'(inc_q - 1'b1);
				state_d   = S_FIN_W;
			end
			S_FIN_W: state_d = S_SUM;
			S_SUM: begin
				ram_raddr = k_q[AW-1:0];
				state_d   = S_SUM_W;
			end
			S_SUM_W: state_d = S_SUM_A;
			S_SUM_A: state_d = (k_q == last_q) ? S_DIV : S_SUM;
			S_DIV: begin
				if (sum_q == '0) begin
					state_d = S_DONE;
				end else begin
					div_start = 1'b1;
					state_d   = S_DIV_W;
				end
			end
			S_DIV_W: begin
				if (div_done) state_d = S_DONE;
			end
			S_DONE: begin
				if (out_free) state_d = S_LOAD;
			end
			default: state_d = S_LOAD;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_LOAD;
			divisor_q  <= DIVISOR_RST;
			busy_min_q <= BUSY_MIN_RST;
			count_q    <= '0;
			ovf_q      <= 1'b0;
			mark_q     <= '0;
			m_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			// configuration writes
			if (cfg_we) begin
				unique case (cfg_reg_t'(cfg_index))
					REG_DECREASE_DIVISOR: divisor_q  <= cfg_data;
					REG_BUSY_MIN_LENGTH:  busy_min_q <= cfg_data[6:0];
					default: ;
				endcase
			end
			// store packets, flag drops
			if (s_fire) begin
				if (count_q < CW'(MAX_PACKETS)) count_q <= count_q + 1'b1;
				else ovf_q <= 1'b1;
			end
			// mark rising packets of a long excursion
			if (state_q == S_MARK_W && inc_delay_q < rd_eff) begin
				mark_q[mk_q[AW-1:0]] <= 1'b1;
			end
			// publish result and clear chirp state, else drain the output register
			if (state_q == S_DONE && out_free) begin
				m_valid_q <= 1'b1;
				count_q   <= '0;
				ovf_q     <= 1'b0;
				mark_q    <= '0;
			end else if (m_valid_q && m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_LOAD: begin
				if (s_fire && s_tlast) begin
					last_q <= (count_q < CW'(MAX_PACKETS)) ? count_q : count_q - 1'b1;
					nr_i_q <= CW'(1);
				end
			end
			S_NR_RD: begin
				if (nr_i_q >= last_q) begin
					inc_q <= nr_i_q;
					loc_q <= nr_i_q + 1'b1;
					max_q <= '0;
				end
			end
			S_NR_W0: cur_q <= rd_eff;
			S_NR_W1: begin
				if (cur_q >= rd_eff) begin
					nr_i_q <= nr_i_q + 1'b1;
					cur_q  <= rd_eff;
					if ((nr_i_q + 1'b1) >= last_q) begin
						inc_q       <= nr_i_q + 1'b1;
						inc_delay_q <= rd_eff;
						loc_q       <= nr_i_q + CW'(2);
						max_q       <= '0;
					end
				end else begin
					inc_q       <= nr_i_q;
					inc_delay_q <= cur_q;
					loc_q       <= nr_i_q + 1'b1;
					max_q       <= '0;
				end
			end
			S_EXC_W: begin
				if (rd.skip) begin
					loc_q <= loc_q + 1'b1;
				end else if (!exc_end) begin
					max_q <= exc_max;
					loc_q <= loc_q + 1'b1;
				end else begin
					nr_i_q <= loc_q;
					mk_q   <= inc_q;
					end_q  <= loc_q;
				end
			end
			S_MARK_W: begin
				// mark flop uses inc_delay_q as previous delay, advance it
				inc_delay_q <= rd_eff;
				mk_q        <= mk_q + 1'b1;
			end
			S_FIN_W: begin
				base_q <= rd.rate;
				k_q    <= '0;
				sum_q  <= '0;
				acc_q  <= '0;
			end
			S_SUM_W: begin
				prod_s1 <= sel_rate * rd.gap;
				sum_q   <= sum_q + SUMW'(rd.gap);
			end
			S_SUM_A: begin
				acc_q <= acc_q + ACCW'(prod_s1);
				k_q   <= k_q + 1'b1;
			end
			S_DIV: begin
				bw_q <= '0;
				nt_q <= (sum_q == '0);
			end
			S_DIV_W: begin
				if (div_done) bw_q <= div_quo;
			end
			S_DONE: begin
				if (out_free) begin
					m_bw_q    <= bw_q;
					m_flags_q <= {ovf_q, nt_q};
				end
			end
			default: ;
		endcase
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_bw_q;
	assign m_tuser  = m_flags_q;

endmodule
`default_nettype wire

// ----- rtl/ceb_ram.sv -----
// ---------------------------------------------------------------------------
// ceb_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ---------------------------------------------------------------------------
`default_nettype none
module ceb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// ----- rtl/ceb_div.sv -----
// ---------------------------------------------------------------------------
// ceb_div: bit-serial restoring divider
// One quotient bit per cycle; returns the low 32 quotient bits.
// ---------------------------------------------------------------------------
`default_nettype none
module ceb_div (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    start,
	input  wire logic [ceb_pkg::ACCW-1:0] dividend,
	input  wire logic [ceb_pkg::SUMW-1:0] divisor,
	output logic                         done,
	output logic [31:0]                  quotient
);
	import ceb_pkg::*;

	localparam int NW = $clog2(ACCW + 1);

	logic            busy_q;
	logic [NW-1:0]   cnt_q;
	logic [ACCW-1:0] num_q;
	logic [SUMW-1:0] den_q;
	logic [SUMW-1:0] rem_q;
	logic [31:0]     quo_q;
	logic            done_q;
	logic [SUMW:0]   rem_sh;
	logic            fits;

	assign rem_sh = {rem_q, num_q[ACCW-1]};
	assign fits   = rem_sh >= {1'b0, den_q};

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= NW'(ACCW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == NW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// shift one dividend bit into the remainder, subtract when it fits
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			den_q <= divisor;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[ACCW-2:0], 1'b0};
			rem_q <= fits ? SUMW'(rem_sh - {1'b0, den_q}) : rem_sh[SUMW-1:0];
			quo_q <= {quo_q[30:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule
`default_nettype wire
